// ----- rtl/core/ffpa_pkg.sv -----
`timescale 1ns / 1ps
package ffpa_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int MAX_CFG_TYPES = 4;
  localparam int WORD_BITS  = 64;
  localparam logic [4:0] SHIFT_MIN = 5'd12;
  localparam logic [4:0] SHIFT_MAX = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FLAGS_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FLAGS_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_TYPE  = 3'd1,
    ST_ALIGN    = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_UNKNOWN  = 3'd4
  } status_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  handle;
    logic [3:0]  type_mask;
    logic [8:0]  wanted_flags;
    logic [31:0] size_bytes;
    logic [31:0] align_bytes;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  mem_type;
    logic [1:0]  chunk;
    logic [13:0] page_offset;
    logic [14:0] page_count;
    logic [29:0] byte_offset;
  } rsp_t;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    h_sub;
    logic    eval;
    logic    scan;
    logic    next_word;
    logic    next_chunk;
    logic    new_chunk;
    logic    mark_start;
    logic    mark_wr;
    logic    rec_load;
    logic    finish;
    logic    code_we;
    status_t code;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic h_ge;
    logic op_free;
    logic h_valid;
    logic type_found;
    logic align_bad;
    logic too_big;
    logic pages_zero;
    logic found;
    logic grp_last;
    logic word_last;
    logic chunk_more;
    logic chunk_room;
    logic mark_last;
    logic rec_zero;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/ffpa_chan_if.sv -----
`timescale 1ns / 1ps
interface ffpa_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ffpa_ram.sv -----
`timescale 1ns / 1ps
module ffpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- rtl/core/ffpa_ctrl.sv -----
`timescale 1ns / 1ps
module ffpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output ffpa_pkg::cmd_t cmd,
  input  ffpa_pkg::sts_t sts
);
  import ffpa_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_HMOD  = 12'b000000000100,
    S_EVAL  = 12'b000000001000,
    S_SRD   = 12'b000000010000,
    S_SCAN  = 12'b000000100000,
    S_MST   = 12'b000001000000,
    S_MRD   = 12'b000010000000,
    S_MWR   = 12'b000100000000,
    S_HRD   = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.code = ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_HMOD;
        end
      end
      S_HMOD: begin
        // fold the handle into range
        if (sts.h_ge) cmd.h_sub = 1'b1;
        else state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.op_free) begin
          if (!sts.h_valid) begin
            cmd.code_we = 1'b1;
            cmd.code = ST_UNKNOWN;
            state_next = S_DONE;
          end else begin
            state_next = S_HRD;
          end
        end else if (!sts.type_found) begin
          cmd.code_we = 1'b1;
          cmd.code = ST_NO_TYPE;
          state_next = S_DONE;
        end else if (sts.align_bad) begin
          cmd.code_we = 1'b1;
          cmd.code = ST_ALIGN;
          state_next = S_DONE;
        end else if (sts.too_big) begin
          cmd.code_we = 1'b1;
          cmd.code = ST_NO_SPACE;
          state_next = S_DONE;
        end else begin
          cmd.eval = 1'b1;
          state_next = sts.pages_zero ? S_FIN : S_SRD;
        end
      end
      S_SRD: state_next = S_SCAN;
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_next = S_MST;
        end else if (sts.grp_last) begin
          if (!sts.word_last) begin
            cmd.next_word = 1'b1;
            state_next = S_SRD;
          end else if (sts.chunk_more) begin
            cmd.next_chunk = 1'b1;
            state_next = S_SRD;
          end else if (sts.chunk_room) begin
            // a fresh chunk is empty: place the run at its start
            cmd.new_chunk = 1'b1;
            state_next = S_MST;
          end else begin
            cmd.code_we = 1'b1;
            cmd.code = ST_NO_SPACE;
            state_next = S_DONE;
          end
        end
      end
      S_MST: begin
        cmd.mark_start = 1'b1;
        state_next = S_MRD;
      end
      S_MRD: state_next = S_MWR;
      S_MWR: begin
        cmd.mark_wr = 1'b1;
        state_next = sts.mark_last ? S_FIN : S_MRD;
      end
      S_HRD: begin
        cmd.rec_load = 1'b1;
        state_next = sts.rec_zero ? S_FIN : S_MST;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        cmd.code_we = 1'b1;
        cmd.code = ST_OK;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

// ----- rtl/core/ffpa_dp.sv -----
`timescale 1ns / 1ps
module ffpa_dp #(
  parameter int TYPES   = 4,
  parameter int CHUNKS  = 4,
  parameter int PAGES   = 16384,
  parameter int HANDLES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ffpa_pkg::req_t                 req_data,
  input  ffpa_pkg::cmd_t                 cmd,
  output ffpa_pkg::sts_t                 sts,
  output logic                           rsp_valid,
  output ffpa_pkg::rsp_t                 rsp_data,
  input  logic                           rsp_ready
);
  import ffpa_pkg::*;

  localparam int TW    = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int CW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PIW   = WW + 6;
  localparam int OFFW  = $clog2(PAGES);
  localparam int PW    = $clog2(PAGES + 1);
  localparam int ACW   = $clog2(CHUNKS + 1);
  localparam int HW    = $clog2(HANDLES);
  localparam int HRW   = ($clog2(HANDLES + 1) > 8) ? $clog2(HANDLES + 1) : 8;
  localparam int BAW   = TW + CW + WW;
  localparam int RW    = TW + CW + OFFW + PW;
  localparam int NT    = (TYPES < MAX_CFG_TYPES) ? TYPES : MAX_CFG_TYPES;

  // configuration
  logic [2:0] type_count;
  logic [8:0] type_flags [MAX_CFG_TYPES];
  logic [4:0] page_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_count <= 3'd4;
      page_shift <= SHIFT_MIN;
      for (int i = 0; i < MAX_CFG_TYPES; i++) type_flags[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TYPE_COUNT) begin
        type_count <= cfg_data[2:0];
      end else if (cfg_index >= CFG_TYPE_FLAGS_0 && cfg_index <= CFG_TYPE_FLAGS_3) begin
        type_flags[2'(cfg_index - CFG_TYPE_FLAGS_0)] <= cfg_data;
      end else if (cfg_index == CFG_PAGE_SHIFT) begin
        page_shift <= cfg_data[4:0];
      end
    end
  end

  logic [4:0]  sh;
  logic [16:0] pg_size;
  assign sh = (page_shift < SHIFT_MIN) ? SHIFT_MIN :
              (page_shift > SHIFT_MAX) ? SHIFT_MAX : page_shift;
  assign pg_size = 17'd1 << sh;

  // request
  logic           op_r;
  logic [HRW-1:0] hreg;
  logic [3:0]     mask_r;
  logic [8:0]     want_r;
  logic [31:0]    size_r;
  logic [31:0]    align_r;
  logic [HW-1:0]  hidx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= req_data.op;
      hreg    <= HRW'(req_data.handle);
      mask_r  <= req_data.type_mask;
      want_r  <= req_data.wanted_flags;
      size_r  <= req_data.size_bytes;
      align_r <= req_data.align_bytes;
    end else if (cmd.h_sub) begin
      hreg <= hreg - HRW'(HANDLES);
    end
  end
  assign hidx = hreg[HW-1:0];

  // type choice and size checks
  logic          tf;
  logic [TW-1:0] tsel;
  logic [32:0]   pages33;

  always_comb begin
    tf = 1'b0;
    tsel = '0;
    for (int t = 0; t < NT; t++) begin
      if (!tf && 3'(t) < type_count && mask_r[t] &&
          (want_r & type_flags[t]) == want_r) begin
        tf = 1'b1;
        tsel = TW'(t);
      end
    end
  end
  assign pages33 = (33'(size_r) + 33'(pg_size) - 33'd1) >> sh;

  // run state
  logic [TW-1:0]   sel_t;
  logic [CW-1:0]   cur_c;
  logic [WW-1:0]   cur_w;
  logic [2:0]      grp;
  logic [PW-1:0]   run_len;
  logic [OFFW-1:0] run_start;
  logic [OFFW-1:0] off;
  logic [PW-1:0]   n;
  status_t         code_r;
  logic [ACW-1:0]  chunks_active [TYPES];
  logic [ACW-1:0]  active;
  assign active = chunks_active[sel_t];

  // memories
  logic [BAW-1:0]       clr_addr;
  logic [BAW-1:0]       bm_addr;
  logic                 bm_we;
  logic [WORD_BITS-1:0] bm_wdata;
  logic [WORD_BITS-1:0] bm_rd;
  logic [WORD_BITS-1:0] mark_wdata;
  logic [RW-1:0]        rec_rd;
  logic                 rec_we;
  logic                 hvalid [HANDLES];

  assign bm_addr  = {sel_t, cur_c, cur_w};
  assign bm_we    = cmd.clear | cmd.mark_wr;
  assign bm_wdata = cmd.clear ? '0 : mark_wdata;

  ffpa_ram #(.WIDTH(WORD_BITS), .DEPTH(2 ** BAW)) u_bitmap (
    .clk     (clk),
    .wr_en   (bm_we),
    .wr_addr (cmd.clear ? clr_addr : bm_addr),
    .wr_data (bm_wdata),
    .rd_addr (bm_addr),
    .rd_data (bm_rd)
  );

  assign rec_we = cmd.finish && (op_r == OP_ALLOC);

  ffpa_ram #(.WIDTH(RW), .DEPTH(HANDLES)) u_records (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (hidx),
    .wr_data ({sel_t, cur_c, off, n}),
    .rd_addr (hidx),
    .rd_data (rec_rd)
  );

  // one group of eight pages per cycle while a word is scanned; a bitmap read comes between words
  logic [PIW-1:0]  base;
  logic [PIW-1:0]  p;
  logic [PW-1:0]   r;
  logic [OFFW-1:0] s;
  logic [OFFW-1:0] fs;
  logic            f;
  assign base = {cur_w, grp, 3'b000};

  always_comb begin
    r = run_len;
    s = run_start;
    fs = run_start;
    f = 1'b0;
    p = base;
    for (int b = 0; b < 8; b++) begin
      p = base + PIW'(b);
      if (bm_rd[{grp, 3'(b)}] || ({1'b0, p} >= (PIW + 1)'(PAGES))) begin
        r = '0;
      end else begin
        if (r == '0) s = OFFW'(p);
        r = r + 1'b1;
        if (!f && r == n) begin
          f = 1'b1;
          fs = s;
        end
      end
    end
  end

  // run marking, one word per pass
  logic [PIW-1:0]       off_ext;
  logic [PIW:0]         lp;
  logic [WW-1:0]        fw;
  logic [WW-1:0]        lw;
  logic [WORD_BITS-1:0] mmask;

  assign off_ext = PIW'(off);
  assign lp = (PIW + 1)'(off) + (PIW + 1)'(n) - 1'b1;
  assign fw = off_ext[PIW-1:6];
  assign lw = lp[PIW-1:6];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mmask[b] = (cur_w != fw || 6'(b) >= off_ext[5:0]) &&
                 (cur_w != lw || 6'(b) <= lp[5:0]);
    end
  end
  assign mark_wdata = (op_r == OP_ALLOC) ? (bm_rd | mmask) : (bm_rd & ~mmask);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TYPES; t++) chunks_active[t] <= ACW'(1);
      for (int h = 0; h < HANDLES; h++) hvalid[h] <= 1'b0;
    end else begin
      if (cmd.new_chunk) chunks_active[sel_t] <= active + 1'b1;
      if (cmd.rec_load) hvalid[hidx] <= 1'b0;
      if (rec_we) hvalid[hidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      sel_t     <= tsel;
      n         <= PW'(pages33);
      cur_c     <= '0;
      cur_w     <= '0;
      grp       <= '0;
      run_len   <= '0;
      run_start <= '0;
      off       <= '0;
    end
    if (cmd.scan) begin
      run_len   <= r;
      run_start <= s;
      grp       <= grp + 1'b1;
      if (f) off <= fs;
    end
    if (cmd.next_word) cur_w <= cur_w + 1'b1;
    if (cmd.next_chunk) begin
      cur_c   <= cur_c + 1'b1;
      cur_w   <= '0;
      run_len <= '0;
    end
    if (cmd.new_chunk) begin
      cur_c <= CW'(active);
      off   <= '0;
    end
    if (cmd.mark_start) cur_w <= fw;
    if (cmd.mark_wr) cur_w <= cur_w + 1'b1;
    if (cmd.rec_load) begin
      {sel_t, cur_c, off, n} <= rec_rd;
    end
    if (cmd.code_we) code_r <= cmd.code;
  end

  // output register
  logic [31:0] bo;
  assign bo = 32'(off) << sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_data.status <= code_r;
      if (code_r == ST_OK) begin
        rsp_data.mem_type    <= 2'(sel_t);
        rsp_data.chunk       <= 2'(cur_c);
        rsp_data.page_offset <= 14'(off);
        rsp_data.page_count  <= 15'(n);
        rsp_data.byte_offset <= bo[29:0];
      end else begin
        rsp_data.mem_type    <= '0;
        rsp_data.chunk       <= '0;
        rsp_data.page_offset <= '0;
        rsp_data.page_count  <= '0;
        rsp_data.byte_offset <= '0;
      end
    end
  end

  // status back to the controller
  always_comb begin
    sts.clr_last   = (clr_addr == '1);
    sts.h_ge       = (hreg >= HRW'(HANDLES));
    sts.op_free    = (op_r == OP_FREE);
    sts.h_valid    = hvalid[hidx];
    sts.type_found = tf;
    sts.align_bad  = ({1'b0, align_r} > 33'(pg_size));
    sts.too_big    = (pages33 > 33'(PAGES));
    sts.pages_zero = (pages33 == '0);
    sts.found      = f;
    sts.grp_last   = (grp == 3'd7);
    sts.word_last  = (cur_w == WW'(WORDS - 1));
    sts.chunk_more = ((ACW'(cur_c) + 1'b1) < active);
    sts.chunk_room = (active < ACW'(CHUNKS));
    sts.mark_last  = (cur_w == lw);
    sts.rec_zero   = (rec_rd[PW-1:0] == '0);
    sts.out_free   = !rsp_valid || rsp_ready;
  end
endmodule

// ----- rtl/core/first_fit_page_allocator.sv -----
`timescale 1ns / 1ps
// First-fit page allocator. After reset the block sweeps the occupancy bitmap
// clear, one 64-page word per cycle, and takes no request until done;
// configuration writes are taken throughout. One request is in flight at a
// time. Each request first folds its handle into range. An allocate scans the
// chosen type's active chunks at 8 pages per cycle, with a bitmap read between
// 64-page words, then marks the run one word at a time, reading and then
// writing each word touched; a free reads the handle's record and clears its
// run the same way. A finished result waits in an output register.
module first_fit_page_allocator #(
  parameter int TYPES   = 4,
  parameter int CHUNKS  = 4,
  parameter int PAGES   = 16384,
  parameter int HANDLES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffpa_pkg::CFG_DATA_W-1:0] cfg_data,
  ffpa_chan_if.sink                      req,
  ffpa_chan_if.source                    rsp
);
  import ffpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffpa_dp #(
    .TYPES   (TYPES),
    .CHUNKS  (CHUNKS),
    .PAGES   (PAGES),
    .HANDLES (HANDLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req.data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp.valid),
    .rsp_data  (rsp.data),
    .rsp_ready (rsp.ready)
  );
endmodule
